[rtl/core/modd_pkg.sv]
// Shared types, codes and sub-table lookups for the opcode dispatch decoder.
package modd_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned IdW    = 7;
	localparam int unsigned GroupW = 4;

	typedef logic [IdW-1:0]    op_id_t;
	typedef logic [GroupW-1:0] group_t;

	// sub-table codes
	localparam group_t GRP_PRIMARY = 4'd0;
	localparam group_t GRP_SPECIAL = 4'd1;
	localparam group_t GRP_REGIMM  = 4'd2;
	localparam group_t GRP_COP0    = 4'd3;
	localparam group_t GRP_COP1    = 4'd4;
	localparam group_t GRP_FPUS    = 4'd5;
	localparam group_t GRP_COP2    = 4'd6;
	localparam group_t GRP_TLB     = 4'd7;
	localparam group_t GRP_MMI     = 4'd8;
	localparam group_t GRP_MMI1    = 4'd9;
	localparam group_t GRP_MMI2    = 4'd10;
	localparam group_t GRP_MMI3    = 4'd11;
	localparam group_t GRP_LAST    = GRP_MMI3;

	localparam op_id_t OP_UNKNOWN   = 7'd0;
	localparam op_id_t OP_COP2_STUB = 7'd1;
	localparam op_id_t OP_LAST      = 7'd91;

	// opcode field values that redirect to a sub-table
	localparam logic [5:0] OPC_SPECIAL = 6'd0;
	localparam logic [5:0] OPC_REGIMM  = 6'd1;
	localparam logic [5:0] OPC_COP0    = 6'd16;
	localparam logic [5:0] OPC_COP1    = 6'd17;
	localparam logic [5:0] OPC_COP2    = 6'd18;
	localparam logic [5:0] OPC_MMI     = 6'd28;

	localparam logic [4:0] RS_CO      = 5'd16;
	localparam logic [5:0] FN_MMI2    = 6'd9;
	localparam logic [5:0] FN_MMI1    = 6'd40;
	localparam logic [5:0] FN_MMI3    = 6'd41;

	typedef struct packed {
		op_id_t operation_id;
		group_t table_group;
		logic   is_unknown;
	} dec_result_t;

	function automatic op_id_t lut_primary(input logic [5:0] idx);
		op_id_t r;
		case (idx)
			6'd2:  r = 7'd2;
			6'd3:  r = 7'd3;
			6'd4:  r = 7'd4;
			6'd5:  r = 7'd5;
			6'd6:  r = 7'd6;
			6'd7:  r = 7'd7;
			6'd9:  r = 7'd8;
			6'd10: r = 7'd9;
			6'd11: r = 7'd10;
			6'd12: r = 7'd11;
			6'd13: r = 7'd12;
			6'd14: r = 7'd13;
			6'd15: r = 7'd14;
			6'd20: r = 7'd15;
			6'd21: r = 7'd16;
			6'd25: r = 7'd17;
			6'd26: r = 7'd18;
			6'd27: r = 7'd19;
			6'd30: r = 7'd20;
			6'd31: r = 7'd21;
			6'd32: r = 7'd22;
			6'd33: r = 7'd23;
			6'd35: r = 7'd24;
			6'd36: r = 7'd25;
			6'd37: r = 7'd26;
			6'd39: r = 7'd27;
			6'd40: r = 7'd28;
			6'd41: r = 7'd29;
			6'd43: r = 7'd30;
			6'd44: r = 7'd31;
			6'd45: r = 7'd32;
			6'd47: r = 7'd33;
			6'd55: r = 7'd34;
			6'd57: r = 7'd35;
			6'd63: r = 7'd36;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_id_t lut_special(input logic [5:0] idx);
		op_id_t r;
		case (idx)
			6'd0:  r = 7'd37;
			6'd2:  r = 7'd38;
			6'd3:  r = 7'd39;
			6'd4:  r = 7'd40;
			6'd6:  r = 7'd41;
			6'd7:  r = 7'd42;
			6'd8:  r = 7'd43;
			6'd9:  r = 7'd44;
			6'd10: r = 7'd45;
			6'd11: r = 7'd46;
			6'd12: r = 7'd47;
			6'd13: r = 7'd48;
			6'd15: r = 7'd49;
			6'd16: r = 7'd50;
			6'd18: r = 7'd51;
			6'd20: r = 7'd52;
			6'd23: r = 7'd53;
			6'd24: r = 7'd54;
			6'd26: r = 7'd55;
			6'd27: r = 7'd56;
			6'd33: r = 7'd57;
			6'd35: r = 7'd58;
			6'd36: r = 7'd59;
			6'd37: r = 7'd60;
			6'd39: r = 7'd61;
			6'd42: r = 7'd62;
			6'd43: r = 7'd63;
			6'd45: r = 7'd64;
			6'd47: r = 7'd65;
			6'd56: r = 7'd66;
			6'd58: r = 7'd67;
			6'd60: r = 7'd68;
			6'd62: r = 7'd69;
			6'd63: r = 7'd70;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_id_t lut_regimm(input logic [4:0] idx);
		op_id_t r;
		case (idx)
			5'd0: r = 7'd71;
			5'd1: r = 7'd72;
			5'd2: r = 7'd73;
			5'd3: r = 7'd74;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_id_t lut_cop0(input logic [4:0] idx);
		op_id_t r;
		case (idx)
			5'd0: r = 7'd75;
			5'd4: r = 7'd76;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_id_t lut_cop1(input logic [4:0] idx);
		op_id_t r;
		case (idx)
			5'd4: r = 7'd77;
			5'd6: r = 7'd78;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_id_t lut_fpus(input logic [5:0] idx);
		op_id_t r;
		case (idx)
			6'd24: r = 7'd79;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	// unlisted cop2 slots fall to the stub, never to unknown
	function automatic op_id_t lut_cop2(input logic [4:0] idx);
		op_id_t r;
		case (idx)
			5'd2: r = 7'd80;
			5'd6: r = 7'd81;
			default: r = OP_COP2_STUB;
		endcase
		return r;
	endfunction

	function automatic op_id_t lut_tlb(input logic [5:0] idx);
		op_id_t r;
		case (idx)
			6'd2:  r = 7'd82;
			6'd24: r = 7'd83;
			6'd56: r = 7'd84;
			6'd57: r = 7'd85;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_id_t lut_mmi(input logic [5:0] idx);
		op_id_t r;
		case (idx)
			6'd4:  r = 7'd86;
			6'd18: r = 7'd87;
			6'd24: r = 7'd88;
			6'd27: r = 7'd89;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_id_t lut_mmi1(input logic [4:0] idx);
		op_id_t r;
		case (idx)
			5'd16: r = 7'd90;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_id_t lut_mmi3(input logic [4:0] idx);
		op_id_t r;
		case (idx)
			5'd18: r = 7'd91;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/modd_decode.sv]
// Combinational field split, sub-table select and lookup for one instruction word.
module modd_decode (
	input  logic [modd_pkg::WordW-1:0] word,
	output modd_pkg::dec_result_t      res
);
	import modd_pkg::*;

	logic [5:0] opc;
	logic [4:0] rs;
	logic [4:0] rt;
	logic [4:0] imm5;
	logic [5:0] fn;
	op_id_t     id;
	group_t     grp;

	assign opc  = word[31:26];
	assign rs   = word[25:21];
	assign rt   = word[20:16];
	assign imm5 = word[10:6];
	assign fn   = word[5:0];

	always_comb begin
		case (opc)
			OPC_SPECIAL: begin
				grp = GRP_SPECIAL;
				id  = lut_special(fn);
			end
			OPC_REGIMM: begin
				grp = GRP_REGIMM;
				id  = lut_regimm(rt);
			end
			OPC_COP0: begin
				if (rs == RS_CO) begin
					grp = GRP_TLB;
					id  = lut_tlb(fn);
				end else begin
					grp = GRP_COP0;
					id  = lut_cop0(rs);
				end
			end
			OPC_COP1: begin
				if (rs == RS_CO) begin
					grp = GRP_FPUS;
					id  = lut_fpus(fn);
				end else begin
					grp = GRP_COP1;
					id  = lut_cop1(rs);
				end
			end
			OPC_COP2: begin
				grp = GRP_COP2;
				id  = lut_cop2(rs);
			end
			OPC_MMI: begin
				// mmi2 has no entries at all
				if (fn == FN_MMI2) begin
					grp = GRP_MMI2;
					id  = OP_UNKNOWN;
				end else if (fn == FN_MMI1) begin
					grp = GRP_MMI1;
					id  = lut_mmi1(imm5);
				end else if (fn == FN_MMI3) begin
					grp = GRP_MMI3;
					id  = lut_mmi3(imm5);
				end else begin
					grp = GRP_MMI;
					id  = lut_mmi(fn);
				end
			end
			default: begin
				grp = GRP_PRIMARY;
				id  = lut_primary(opc);
			end
		endcase
	end

	assign res.operation_id = id;
	assign res.table_group  = grp;
	assign res.is_unknown   = (id == OP_UNKNOWN);

endmodule

[rtl/core/mips_opcode_dispatch_decoder_top.sv]
// Top level: input register, decode logic and output register with stream handshakes.
// Path: an accepted item is held in the input register, decoded combinationally, then
//   loaded into the result register, where it is offered until taken; a stalled output
//   holds the result register and a full input register.
// Throughput: one item per cycle; both stages advance together whenever the result
//   register is empty or being taken.
// Reset: arst_n clears both valid flags asynchronously; the data registers are not reset.
module mips_opcode_dispatch_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] instruction_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [6:0] operation_id, [7] zero
	output logic [4:0]  m_axis_tuser   // [3:0] table_group, [4] is_unknown
);
	import modd_pkg::*;

	logic               valid_s1;
	logic [WordW-1:0]   word_s1;
	logic               valid_s2;
	dec_result_t        res_s2;
	dec_result_t        dec_res;
	logic               adv_s2;
	logic               adv_s1;

	// stage 2 can load when empty or its item is leaving
	assign adv_s2 = !valid_s2 || m_axis_tready;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			word_s1 <= s_axis_tdata;
		end
	end

	modd_decode u_decode (
		.word (word_s1),
		.res  (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= dec_res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, res_s2.operation_id};
	assign m_axis_tuser  = {res_s2.is_unknown, res_s2.table_group};

endmodule

[rtl/core/modd_checker.sv]
// Port-level checks for the decoder top and the bind that attaches them.
module modd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic [4:0]  m_axis_tuser
);
	import modd_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_unknown_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[4] == (m_axis_tdata[6:0] == OP_UNKNOWN))
		else $error("unknown flag disagrees with operation id");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[3:0] <= GRP_LAST && m_axis_tdata[6:0] <= OP_LAST
			&& !m_axis_tdata[7])
		else $error("result field out of range");

	a_stub_group: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6:0] == OP_COP2_STUB |-> m_axis_tuser[3:0] == GRP_COP2)
		else $error("cop2 stub outside cop2 group");

	// an item accepted while no result is shown, followed by a free output, then shows at the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid ##1 m_axis_tready && s_axis_tready
			|=> m_axis_tvalid)
		else $error("accepted item did not reach the output");

endmodule

bind mips_opcode_dispatch_decoder_top modd_checker u_modd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

[verif/testbench.sv]
// Stream testbench for the opcode dispatch decoder: directed and random words, checked per item.
`timescale 1ns / 100ps

module testbench;
	import modd_pkg::*;

	typedef enum logic [1:0] {
		PH_STEADY,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} phase_t;

	typedef struct {
		logic [31:0] word;
		phase_t      phase;
	} instr_item_t;

	localparam int unsigned RANDOM_WORDS = 650;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] instruction_word
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [6:0] operation_id, [7] zero
	logic [4:0]  m_axis_tuser;        // [3:0] table_group, [4] is_unknown

	instr_item_t pending_words[$];
	dec_result_t expected_decodes[$];

	phase_t      cur_phase = PH_STEADY;
	int unsigned fail_count = 0;
	int unsigned decodes_checked = 0;
	int unsigned unknown_seen = 0;
	int unsigned quiet_cycles = 0;
	logic [11:0] groups_seen = '0;
	int unsigned directed_count = 0;
	int unsigned send_idle;
	int unsigned recv_stall;
	dec_result_t want;

	mips_opcode_dispatch_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] pack_word(input logic [5:0] opc, input logic [4:0] rs,
			input logic [4:0] rt, input logic [4:0] sa, input logic [5:0] fn);
		return {opc, rs, rt, 5'd0, sa, fn};
	endfunction

	// Expected decode of one instruction word
	function automatic dec_result_t decode_instr(input logic [31:0] w);
		logic [5:0]  opc;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  sa;
		logic [5:0]  fn;
		logic [5:0]  idx;
		dec_result_t r;
		opc = w[31:26];
		rs  = w[25:21];
		rt  = w[20:16];
		sa  = w[10:6];
		fn  = w[5:0];
		case (opc)
			OPC_SPECIAL: begin
				r.table_group = GRP_SPECIAL;
				idx = fn;
			end
			OPC_REGIMM: begin
				r.table_group = GRP_REGIMM;
				idx = {1'b0, rt};
			end
			OPC_COP0: begin
				r.table_group = (rs == RS_CO) ? GRP_TLB : GRP_COP0;
				idx = (rs == RS_CO) ? fn : {1'b0, rs};
			end
			OPC_COP1: begin
				r.table_group = (rs == RS_CO) ? GRP_FPUS : GRP_COP1;
				idx = (rs == RS_CO) ? fn : {1'b0, rs};
			end
			OPC_COP2: begin
				r.table_group = GRP_COP2;
				idx = {1'b0, rs};
			end
			OPC_MMI: begin
				idx = {1'b0, sa};
				if (fn == FN_MMI2)
					r.table_group = GRP_MMI2;
				else if (fn == FN_MMI1)
					r.table_group = GRP_MMI1;
				else if (fn == FN_MMI3)
					r.table_group = GRP_MMI3;
				else begin
					r.table_group = GRP_MMI;
					idx = fn;
				end
			end
			default: begin
				r.table_group = GRP_PRIMARY;
				idx = opc;
			end
		endcase

		r.operation_id = OP_UNKNOWN;
		case (r.table_group)
			GRP_PRIMARY: begin
				case (idx)
					6'd2: r.operation_id = 7'd2;    6'd3: r.operation_id = 7'd3;
					6'd4: r.operation_id = 7'd4;    6'd5: r.operation_id = 7'd5;
					6'd6: r.operation_id = 7'd6;    6'd7: r.operation_id = 7'd7;
					6'd9: r.operation_id = 7'd8;    6'd10: r.operation_id = 7'd9;
					6'd11: r.operation_id = 7'd10;  6'd12: r.operation_id = 7'd11;
					6'd13: r.operation_id = 7'd12;  6'd14: r.operation_id = 7'd13;
					6'd15: r.operation_id = 7'd14;  6'd20: r.operation_id = 7'd15;
					6'd21: r.operation_id = 7'd16;  6'd25: r.operation_id = 7'd17;
					6'd26: r.operation_id = 7'd18;  6'd27: r.operation_id = 7'd19;
					6'd30: r.operation_id = 7'd20;  6'd31: r.operation_id = 7'd21;
					6'd32: r.operation_id = 7'd22;  6'd33: r.operation_id = 7'd23;
					6'd35: r.operation_id = 7'd24;  6'd36: r.operation_id = 7'd25;
					6'd37: r.operation_id = 7'd26;  6'd39: r.operation_id = 7'd27;
					6'd40: r.operation_id = 7'd28;  6'd41: r.operation_id = 7'd29;
					6'd43: r.operation_id = 7'd30;  6'd44: r.operation_id = 7'd31;
					6'd45: r.operation_id = 7'd32;  6'd47: r.operation_id = 7'd33;
					6'd55: r.operation_id = 7'd34;  6'd57: r.operation_id = 7'd35;
					6'd63: r.operation_id = 7'd36;
					default: r.operation_id = OP_UNKNOWN;
				endcase
			end
			GRP_SPECIAL: begin
				case (idx)
					6'd0: r.operation_id = 7'd37;   6'd2: r.operation_id = 7'd38;
					6'd3: r.operation_id = 7'd39;   6'd4: r.operation_id = 7'd40;
					6'd6: r.operation_id = 7'd41;   6'd7: r.operation_id = 7'd42;
					6'd8: r.operation_id = 7'd43;   6'd9: r.operation_id = 7'd44;
					6'd10: r.operation_id = 7'd45;  6'd11: r.operation_id = 7'd46;
					6'd12: r.operation_id = 7'd47;  6'd13: r.operation_id = 7'd48;
					6'd15: r.operation_id = 7'd49;  6'd16: r.operation_id = 7'd50;
					6'd18: r.operation_id = 7'd51;  6'd20: r.operation_id = 7'd52;
					6'd23: r.operation_id = 7'd53;  6'd24: r.operation_id = 7'd54;
					6'd26: r.operation_id = 7'd55;  6'd27: r.operation_id = 7'd56;
					6'd33: r.operation_id = 7'd57;  6'd35: r.operation_id = 7'd58;
					6'd36: r.operation_id = 7'd59;  6'd37: r.operation_id = 7'd60;
					6'd39: r.operation_id = 7'd61;  6'd42: r.operation_id = 7'd62;
					6'd43: r.operation_id = 7'd63;  6'd45: r.operation_id = 7'd64;
					6'd47: r.operation_id = 7'd65;  6'd56: r.operation_id = 7'd66;
					6'd58: r.operation_id = 7'd67;  6'd60: r.operation_id = 7'd68;
					6'd62: r.operation_id = 7'd69;  6'd63: r.operation_id = 7'd70;
					default: r.operation_id = OP_UNKNOWN;
				endcase
			end
			GRP_REGIMM: begin
				if (idx <= 6'd3)
					r.operation_id = 7'd71 + {1'b0, idx};
			end
			GRP_COP0: begin
				if (idx == 6'd0)
					r.operation_id = 7'd75;
				else if (idx == 6'd4)
					r.operation_id = 7'd76;
			end
			GRP_COP1: begin
				if (idx == 6'd4)
					r.operation_id = 7'd77;
				else if (idx == 6'd6)
					r.operation_id = 7'd78;
			end
			GRP_FPUS: begin
				if (idx == 6'd24)
					r.operation_id = 7'd79;
			end
			// any cop2 slot without an entry lands on the stub
			GRP_COP2: begin
				if (idx == 6'd2)
					r.operation_id = 7'd80;
				else if (idx == 6'd6)
					r.operation_id = 7'd81;
				else
					r.operation_id = OP_COP2_STUB;
			end
			GRP_TLB: begin
				case (idx)
					6'd2: r.operation_id = 7'd82;   6'd24: r.operation_id = 7'd83;
					6'd56: r.operation_id = 7'd84;  6'd57: r.operation_id = 7'd85;
					default: r.operation_id = OP_UNKNOWN;
				endcase
			end
			GRP_MMI: begin
				case (idx)
					6'd4: r.operation_id = 7'd86;   6'd18: r.operation_id = 7'd87;
					6'd24: r.operation_id = 7'd88;  6'd27: r.operation_id = 7'd89;
					default: r.operation_id = OP_UNKNOWN;
				endcase
			end
			GRP_MMI1: begin
				if (idx == 6'd16)
					r.operation_id = 7'd90;
			end
			GRP_MMI3: begin
				if (idx == 6'd18)
					r.operation_id = 7'd91;
			end
			default: r.operation_id = OP_UNKNOWN;  // mmi2 is empty
		endcase
		r.is_unknown = (r.operation_id == OP_UNKNOWN);
		return r;
	endfunction

	task automatic queue_word(input logic [31:0] w, input phase_t ph);
		instr_item_t it;
		it.word  = w;
		it.phase = ph;
		pending_words.push_back(it);
	endtask

	// Driver: presents queued words, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_decodes.push_back(decode_instr(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				send_idle = 0;
				if (pending_words.size() != 0) begin
					case (pending_words[0].phase)
						PH_SEND_IDLE: send_idle = 87;
						PH_BOTH:      send_idle = 14;
						default:      send_idle = 0;
					endcase
				end
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
					cur_phase     <= pending_words[0].phase;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pending_words[0].word;
					void'(pending_words.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
					s_axis_tdata  <= $urandom;  // junk while idle
				end
			end
		end
	end

	// Monitor: checks results, stalls the output, watches for a hang
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_decodes.size() == 0) begin
					$error("result with no item pending: operation_id %0d table_group %0d",
						m_axis_tdata[6:0], m_axis_tuser[3:0]);
					fail_count++;
				end else begin
					want = expected_decodes.pop_front();
					decodes_checked++;
					if (m_axis_tdata[6:0] !== want.operation_id) begin
						$error("operation_id: expected %0d, got %0d",
							want.operation_id, m_axis_tdata[6:0]);
						fail_count++;
					end
					if (m_axis_tuser[3:0] !== want.table_group) begin
						$error("table_group: expected %0d, got %0d",
							want.table_group, m_axis_tuser[3:0]);
						fail_count++;
					end
					if (m_axis_tuser[4] !== want.is_unknown) begin
						$error("is_unknown: expected %0d, got %0d",
							want.is_unknown, m_axis_tuser[4]);
						fail_count++;
					end
					if (want.is_unknown)
						unknown_seen++;
					groups_seen[want.table_group] = 1'b1;
				end
			end

			case (cur_phase)
				PH_RECV_STALL: recv_stall = 87;
				PH_BOTH:       recv_stall = 14;
				default:       recv_stall = 0;
			endcase
			m_axis_tready <= ($urandom_range(99) >= recv_stall);

			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] w;
		phase_t      ph;
		int          sel;

		// corner words, every sub-table, hits and misses
		queue_word(32'h0000_0000, PH_STEADY);
		queue_word(32'hFFFF_FFFF, PH_STEADY);
		queue_word(pack_word(OPC_SPECIAL, 5'd31, 5'd31, 5'd31, 6'd1), PH_STEADY);
		queue_word(pack_word(OPC_SPECIAL, 5'd0, 5'd0, 5'd0, 6'd63), PH_STEADY);
		queue_word(pack_word(OPC_REGIMM, 5'd0, 5'd3, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(OPC_REGIMM, 5'd0, 5'd31, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(OPC_COP0, 5'd0, 5'd0, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(OPC_COP0, 5'd4, 5'd0, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(OPC_COP0, 5'd31, 5'd0, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(OPC_COP0, RS_CO, 5'd0, 5'd0, 6'd57), PH_STEADY);
		queue_word(pack_word(OPC_COP0, RS_CO, 5'd0, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(OPC_COP1, 5'd6, 5'd0, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(OPC_COP1, RS_CO, 5'd0, 5'd0, 6'd24), PH_STEADY);
		queue_word(pack_word(OPC_COP1, RS_CO, 5'd0, 5'd0, 6'd63), PH_STEADY);
		queue_word(pack_word(OPC_COP2, 5'd2, 5'd0, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(OPC_COP2, 5'd6, 5'd0, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(OPC_COP2, 5'd31, 5'd31, 5'd31, 6'd63), PH_STEADY);
		queue_word(pack_word(OPC_MMI, 5'd0, 5'd0, 5'd31, FN_MMI2), PH_STEADY);
		queue_word(pack_word(OPC_MMI, 5'd0, 5'd0, 5'd16, FN_MMI1), PH_STEADY);
		queue_word(pack_word(OPC_MMI, 5'd0, 5'd0, 5'd0, FN_MMI1), PH_STEADY);
		queue_word(pack_word(OPC_MMI, 5'd0, 5'd0, 5'd18, FN_MMI3), PH_STEADY);
		queue_word(pack_word(OPC_MMI, 5'd0, 5'd0, 5'd0, 6'd27), PH_STEADY);
		queue_word(pack_word(OPC_MMI, 5'd0, 5'd0, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(6'd8, 5'd0, 5'd0, 5'd0, 6'd0), PH_STEADY);
		queue_word(pack_word(6'd2, 5'd0, 5'd0, 5'd0, 6'd0), PH_STEADY);
		directed_count = pending_words.size();

		// random words, biased toward the redirecting opcodes and their live slots
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			w   = $urandom;
			sel = $urandom_range(11);
			case (sel)
				0: w[31:26] = OPC_SPECIAL;
				1: begin
					w[31:26] = OPC_REGIMM;
					if ($urandom_range(1))
						w[20:16] = 5'($urandom_range(4));
				end
				2, 3: begin
					w[31:26] = (sel == 2) ? OPC_COP0 : OPC_COP1;
					case ($urandom_range(3))
						0: w[25:21] = RS_CO;
						1: w[25:21] = $urandom_range(1) ? 5'd4 : ((sel == 2) ? 5'd0 : 5'd6);
						default: ;
					endcase
					if (w[25:21] == RS_CO && $urandom_range(1)) begin
						case ($urandom_range(3))
							0: w[5:0] = 6'd2;
							1: w[5:0] = 6'd24;
							2: w[5:0] = 6'd56;
							default: w[5:0] = 6'd57;
						endcase
					end
				end
				4: begin
					w[31:26] = OPC_COP2;
					if ($urandom_range(1))
						w[25:21] = $urandom_range(1) ? 5'd2 : 5'd6;
				end
				5, 6: begin
					w[31:26] = OPC_MMI;
					case ($urandom_range(4))
						0: w[5:0] = FN_MMI2;
						1: begin
							w[5:0] = FN_MMI1;
							if ($urandom_range(1))
								w[10:6] = 5'd16;
						end
						2: begin
							w[5:0] = FN_MMI3;
							if ($urandom_range(1))
								w[10:6] = 5'd18;
						end
						3: begin
							case ($urandom_range(3))
								0: w[5:0] = 6'd4;
								1: w[5:0] = 6'd18;
								2: w[5:0] = 6'd24;
								default: w[5:0] = 6'd27;
							endcase
						end
						default: ;
					endcase
				end
				default: ;  // fully random word, mostly primary opcodes
			endcase
			ph = phase_t'((i * 4) / RANDOM_WORDS);
			queue_word(w, ph);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// the watchdog ends the run if results stop coming
		while (decodes_checked < directed_count + RANDOM_WORDS)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("decoded %0d words (%0d directed, %0d random) over four idle/stall mixes",
			decodes_checked, directed_count, RANDOM_WORDS);
		$display("sub-tables reached: %0d of 12, unknown encodings: %0d",
			$countones(groups_seen), unknown_seen);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/modd_pkg.sv
rtl/core/modd_decode.sv
rtl/core/mips_opcode_dispatch_decoder_top.sv
rtl/core/modd_checker.sv
verif/testbench.sv
